>>> rtl/gea_pkg.sv
// Shared types, opcodes and helpers for the grid element-wise aggregator.
`timescale 1ns / 1ps
package gea_pkg;

  // Operand slots: four grids then two scalars
  localparam int NUM_GRIDS   = 4;
  localparam int NUM_SCALARS = 2;
  localparam int NV          = NUM_GRIDS + NUM_SCALARS;
  localparam int QW          = 32;
  localparam int SUMW        = 35;
  localparam int DIVW        = 48;
  localparam int CHAIN_DEPTH = 2 * NV;

  typedef enum logic [3:0] {
    OP_SUM = 4'd0,
    OP_MAX = 4'd1,
    OP_MIN = 4'd2,
    OP_AVG = 4'd3,
    OP_MUL = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_SUB = 4'd8,
    OP_DIV = 4'd9,
    OP_NOT = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    CFG_OPERATION    = 3'd0,
    CFG_GRID_COUNT   = 3'd1,
    CFG_SCALAR_COUNT = 3'd2,
    CFG_SCALAR_ZERO  = 3'd3,
    CFG_SCALAR_ONE   = 3'd4,
    CFG_SCALAR_LEADS = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_DIVZERO = 2'd2
  } status_e;

  localparam logic [QW-1:0] ONE_Q = 32'h0001_0000;
  localparam logic [QW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] Q_MIN = 32'h8000_0000;

  // Front-end and product/extremum chain word
  typedef struct packed {
    logic [3:0]             op;
    logic [2:0]             n;
    logic [NV-1:0][QW-1:0]  v;
    logic signed [QW-1:0]   l;
    logic signed [QW-1:0]   r;
    logic signed [SUMW-1:0] sum;
    logic [QW-1:0]          lres;
    logic                   lsat;
    logic signed [QW-1:0]   acc;
    logic signed [63:0]     prod;
    logic signed [QW-1:0]   mx;
    logic                   sat;
  } chain_t;

  // Result carried alongside the divider
  typedef struct packed {
    logic          use_div;
    logic          neg;
    logic [QW-1:0] res;
    logic [1:0]    status;
  } mid_t;

  typedef struct packed {
    mid_t            side;
    logic [DIVW-1:0] dvd;
    logic [QW-1:0]   dvs;
  } div_in_t;

  typedef struct packed {
    mid_t            side;
    logic [DIVW-1:0] quo;
  } div_out_t;

  // Saturate a wide signed value to Q16.16; top bit flags saturation
  function automatic logic [QW:0] sat_q(input logic signed [DIVW-1:0] x);
    logic [QW:0] r;
    if (x > 48'sd2147483647) r = {1'b1, Q_MAX};
    else if (x < -48'sd2147483648) r = {1'b1, Q_MIN};
    else r = {1'b0, x[QW-1:0]};
    return r;
  endfunction

  // Magnitude of a Q16.16 value as unsigned
  function automatic logic [QW-1:0] mag_q(input logic [QW-1:0] x);
    return x[QW-1] ? (~x + 32'd1) : x;
  endfunction

endpackage

>>> rtl/gea_divpipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
module gea_divpipe import gea_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     vld_i,
  input  div_in_t  din_i,
  output logic     vld_o,
  output div_out_t dout_o
);

  typedef struct packed {
    mid_t            side;
    logic [QW-1:0]   rem;
    logic [DIVW-1:0] dq;
    logic [QW-1:0]   dvs;
  } dstage_t;

  dstage_t st_q [DIVW+1];
  dstage_t st_d [DIVW+1];
  logic    vld_q [DIVW+1];

  // Each stage shifts in one dividend bit and tries a subtract
  always_comb begin
    logic [QW:0] sh;
    logic        ge;
    st_d[0] = '{side: din_i.side, rem: '0, dq: din_i.dvd, dvs: din_i.dvs};
    for (int j = 0; j < DIVW; j++) begin
      sh = {st_q[j].rem, st_q[j].dq[DIVW-1]};
      ge = (sh >= {1'b0, st_q[j].dvs});
      st_d[j+1]      = st_q[j];
      st_d[j+1].rem  = ge ? QW'(sh - {1'b0, st_q[j].dvs}) : sh[QW-1:0];
      st_d[j+1].dq   = {st_q[j].dq[DIVW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j <= DIVW; j++) st_q[j] <= st_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= DIVW; j++) vld_q[j] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int j = 0; j < DIVW; j++) vld_q[j+1] <= vld_q[j];
    end
  end

  assign vld_o       = vld_q[DIVW];
  assign dout_o.side = st_q[DIVW].side;
  assign dout_o.quo  = st_q[DIVW].dq;

endmodule

>>> rtl/grid_elementwise_aggregator.sv
// Top level of the grid element-wise aggregator.
`timescale 1ns / 1ps
// Combines one cell of up to four grids with up to two scalars under the
// configured opcode, all in signed Q16.16. One word is accepted per cycle
// while the output is not stalled, and results leave in order through 12
// stages of operand capture, sum and a five-step product/extremum chain, then
// 49 stages of a bit-per-stage divider (used by divide and average), then the
// output register. A stall on the output freezes the whole pipeline. Write the
// configuration only while the pipeline is empty.
module grid_elementwise_aggregator import gea_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // cell_a, cell_b, cell_c, cell_d
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [39:0]  m_axis_tdata_o    // combined, status, zero pad
);

  logic [3:0]    op_q;
  logic [2:0]    gc_q;
  logic [1:0]    sc_q;
  logic [QW-1:0] sz_q, s1_q;
  logic          leads_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_SUM;
      gc_q    <= 3'd1;
      sc_q    <= 2'd0;
      sz_q    <= '0;
      s1_q    <= '0;
      leads_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OPERATION:    op_q    <= cfg_data_i[3:0];
        CFG_GRID_COUNT:   gc_q    <= cfg_data_i[2:0];
        CFG_SCALAR_COUNT: sc_q    <= cfg_data_i[1:0];
        CFG_SCALAR_ZERO:  sz_q    <= cfg_data_i;
        CFG_SCALAR_ONE:   s1_q    <= cfg_data_i;
        CFG_SCALAR_LEADS: leads_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  logic [QW-1:0] out_res_q;
  logic [1:0]    out_st_q;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  chain_t chain_q [CHAIN_DEPTH];
  chain_t chain_d [CHAIN_DEPTH];
  logic   cvld_q  [CHAIN_DEPTH];

  // Operand capture, sum/logic stage and product/extremum chain
  always_comb begin
    logic [2:0]               ng, ns;
    logic [NUM_GRIDS-1:0][QW-1:0] grid_v;
    logic signed [QW-1:0]     t;
    logic signed [SUMW-1:0]   s;
    logic [2:0]               trues;
    logic signed [QW:0]       df;
    logic [QW:0]              sq;
    logic signed [QW-1:0]     vk;
    ng = (gc_q == 3'd0) ? 3'd1 : ((gc_q > 3'd4) ? 3'd4 : gc_q);
    ns = (sc_q > 2'd2) ? 3'd2 : {1'b0, sc_q};
    for (int i = 0; i < NUM_GRIDS; i++) grid_v[i] = s_axis_tdata_i[QW*i +: QW];

    chain_d[0]    = '0;
    chain_d[0].op = op_q;
    chain_d[0].n  = ng + ns;
    for (int i = 0; i < NV; i++) begin
      if (3'(i) < ng && i < NUM_GRIDS) chain_d[0].v[i] = grid_v[i];
      else if (3'(i) == ng && ns > 3'd0) chain_d[0].v[i] = sz_q;
      else if (3'(i) == ng + 3'd1 && ns > 3'd1) chain_d[0].v[i] = s1_q;
      else chain_d[0].v[i] = '0;
    end
    chain_d[0].l = grid_v[0];
    chain_d[0].r = (ns > 3'd0) ? sz_q : grid_v[1];
    if (ns > 3'd0 && leads_q) begin
      chain_d[0].l = sz_q;
      chain_d[0].r = grid_v[0];
    end

    // Sum, truth count, logic ops and subtract
    chain_d[1] = chain_q[0];
    s     = '0;
    trues = '0;
    for (int i = 0; i < NV; i++) begin
      t = chain_q[0].v[i];
      s = s + SUMW'(t);
      if (t > 0) trues = trues + 3'd1;
    end
    chain_d[1].sum = s;
    df = {chain_q[0].l[QW-1], chain_q[0].l} - {chain_q[0].r[QW-1], chain_q[0].r};
    sq = sat_q(DIVW'(df));
    chain_d[1].lsat = 1'b0;
    case (chain_q[0].op)
      OP_AND: chain_d[1].lres = (trues == chain_q[0].n) ? ONE_Q : '0;
      OP_OR:  chain_d[1].lres = (trues != 3'd0) ? ONE_Q : '0;
      OP_XOR: chain_d[1].lres = trues[0] ? ONE_Q : '0;
      OP_NOT: chain_d[1].lres = ($signed(chain_q[0].v[0]) > 0) ? '0 : ONE_Q;
      OP_SUB: begin
        chain_d[1].lres = sq[QW-1:0];
        chain_d[1].lsat = sq[QW];
      end
      default: chain_d[1].lres = '0;
    endcase
    chain_d[1].acc = chain_q[0].v[0];
    chain_d[1].mx  = chain_q[0].v[0];
    chain_d[1].sat = 1'b0;

    // Step k: multiply stage then floor/saturate stage
    for (int k = 1; k < NV; k++) begin
      vk = chain_q[2*k-1].v[k];
      chain_d[2*k]      = chain_q[2*k-1];
      chain_d[2*k].prod = chain_q[2*k-1].acc * vk;
      if (3'(k) < chain_q[2*k-1].n) begin
        if (chain_q[2*k-1].op == OP_MAX ? (vk > chain_q[2*k-1].mx)
                                         : (vk < chain_q[2*k-1].mx))
          chain_d[2*k].mx = vk;
      end
      chain_d[2*k+1] = chain_q[2*k];
      sq = sat_q(chain_q[2*k].prod[63:16]);
      if (3'(k) < chain_q[2*k].n) begin
        chain_d[2*k+1].acc = sq[QW-1:0];
        chain_d[2*k+1].sat = chain_q[2*k].sat | sq[QW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < CHAIN_DEPTH; j++) chain_q[j] <= chain_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < CHAIN_DEPTH; j++) cvld_q[j] <= 1'b0;
    end else if (en) begin
      cvld_q[0] <= s_axis_tvalid_i;
      for (int j = 1; j < CHAIN_DEPTH; j++) cvld_q[j] <= cvld_q[j-1];
    end
  end

  // Select the result or set up the divider
  div_in_t dv_in;
  chain_t  ce;
  always_comb begin
    logic [QW:0]       sq;
    logic [SUMW-1:0]   smag;
    ce = chain_q[CHAIN_DEPTH-1];
    dv_in = '0;
    dv_in.dvs = 32'd1;
    sq = sat_q({{(DIVW-SUMW){ce.sum[SUMW-1]}}, ce.sum});
    // Magnitude of the sum, kept at sum width before widening
    smag = ce.sum[SUMW-1] ? (~ce.sum + 35'd1) : ce.sum;
    case (ce.op)
      OP_SUM: begin
        dv_in.side.res    = sq[QW-1:0];
        dv_in.side.status = sq[QW] ? ST_SAT : ST_OK;
      end
      OP_MAX, OP_MIN: dv_in.side.res = ce.mx;
      OP_AVG: begin
        dv_in.side.use_div = 1'b1;
        dv_in.side.neg     = ce.sum[SUMW-1];
        dv_in.dvd = {{(DIVW-SUMW){1'b0}}, smag};
        dv_in.dvs = {29'd0, ce.n};
      end
      OP_MUL: begin
        dv_in.side.res    = ce.acc;
        dv_in.side.status = ce.sat ? ST_SAT : ST_OK;
      end
      OP_AND, OP_OR, OP_XOR, OP_NOT, OP_SUB: begin
        dv_in.side.res    = ce.lres;
        dv_in.side.status = ce.lsat ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (ce.r == 0) begin
          dv_in.side.res    = ce.l[QW-1] ? Q_MIN : Q_MAX;
          dv_in.side.status = ST_DIVZERO;
        end else begin
          dv_in.side.use_div = 1'b1;
          dv_in.side.neg     = ce.l[QW-1] ^ ce.r[QW-1];
          dv_in.dvd = {mag_q(ce.l), 16'd0};
          dv_in.dvs = mag_q(ce.r);
        end
      end
      default: ;
    endcase
  end

  logic     dv_vld;
  div_out_t dv_out;

  gea_divpipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (cvld_q[CHAIN_DEPTH-1]),
    .din_i  (dv_in),
    .vld_o  (dv_vld),
    .dout_o (dv_out)
  );

  // Apply sign and saturate the quotient
  logic [QW-1:0] out_res_d;
  logic [1:0]    out_st_d;
  always_comb begin
    out_res_d = dv_out.side.res;
    out_st_d  = dv_out.side.status;
    if (dv_out.side.use_div) begin
      out_st_d = ST_OK;
      if (dv_out.side.neg) begin
        if (dv_out.quo > 48'd2147483648) begin
          out_res_d = Q_MIN;
          out_st_d  = ST_SAT;
        end else begin
          out_res_d = 32'd0 - dv_out.quo[QW-1:0];
        end
      end else begin
        if (dv_out.quo > 48'd2147483647) begin
          out_res_d = Q_MAX;
          out_st_d  = ST_SAT;
        end else begin
          out_res_d = dv_out.quo[QW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q <= out_res_d;
      out_st_q  <= out_st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= dv_vld;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, out_st_q, out_res_q};

  // Divide by zero always carries a saturated value
  a_divzero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_st_q == ST_DIVZERO) |-> (out_res_q == Q_MAX || out_res_q == Q_MIN))
    else $error("divide-by-zero word without saturated value");

  // Status code three is never produced
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_st_q != 2'd3))
    else $error("undefined status code");

  // Input side is open whenever the output register is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready_o)
    else $error("input blocked with empty output");

endmodule
